@@ hdl/flow_filter_hash_table_core_defines.svh @@
// ---------------------------------------------------------------------------
// flow_filter_hash_table_core_defines
// Assertion macros shared by the flow filter table modules.
// ---------------------------------------------------------------------------
`ifndef FLOW_FILTER_HASH_TABLE_CORE_DEFINES_SVH
`define FLOW_FILTER_HASH_TABLE_CORE_DEFINES_SVH

// expression holds at every clock edge out of reset
`define FFHT_CHECK(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// antecedent implies consequent in the following cycle
`define FFHT_CHECK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/ffht_pkg.sv @@
// ---------------------------------------------------------------------------
// ffht_pkg
// Types, codes and hash helpers of the flow filter table.
// ---------------------------------------------------------------------------
package ffht_pkg;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_LOOKUP = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		STS_OK       = 3'd0,
		STS_DUP      = 3'd1,
		STS_FULL     = 3'd2,
		STS_NOTFOUND = 3'd3,
		STS_BADHDL   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		KIND_EMPTY = 2'd0,
		KIND_INUSE = 2'd1,
		KIND_TOMB  = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_ADD_RD,
		S_ADD_EV,
		S_INC_RD,
		S_INC_EV,
		S_PLACE,
		S_RM_HRD,
		S_RM_HEV,
		S_RM_RD,
		S_RM_EV,
		S_LK_RD,
		S_LK_EV,
		S_DONE
	} eng_state_t;

	localparam logic [8:0] ROUTE_MAX = 9'd511;
	localparam int QDEPTH = 2;

	typedef struct packed {
		logic [7:0]  proto;
		logic [31:0] laddr;
		logic [15:0] lport;
		logic [31:0] raddr;
		logic [15:0] rport;
	} key_t;

	typedef struct packed {
		op_t         op;
		key_t        key;
		logic [15:0] thread;
		logic [7:0]  handle;
		logic        handle_ok;
	} item_t;

	// raw xor of all key fields
	function automatic logic [31:0] raw_xor(key_t k);
		return k.laddr ^ {16'h0, k.lport} ^ k.raddr ^ {16'h0, k.rport} ^ {24'h0, k.proto};
	endfunction

	// xor fold used for the start slot
	function automatic logic [31:0] fold_hash(key_t k);
		logic [31:0] h;
		h = raw_xor(k);
		h = h ^ (h >> 16);
		h = h ^ (h >> 8);
		return h;
	endfunction

	// odd probe step
	function automatic logic [31:0] step_hash(key_t k);
		return raw_xor(k) | 32'd1;
	endfunction

	// query remote fields both zero compare only protocol and local fields
	function automatic logic key_match(key_t e, key_t q);
		logic base;
		base = (e.proto == q.proto) && (e.laddr == q.laddr) && (e.lport == q.lport);
		if (q.raddr == 32'd0 && q.rport == 16'd0)
			return base;
		return base && (e.raddr == q.raddr) && (e.rport == q.rport);
	endfunction

	function automatic key_t wild_key(key_t k);
		key_t w;
		w = k;
		w.raddr = 32'd0;
		w.rport = 16'd0;
		return w;
	endfunction

	function automatic logic [8:0] route_inc(logic [8:0] r);
		return (r == ROUTE_MAX) ? r : r + 9'd1;
	endfunction

endpackage

@@ hdl/ffht_front.sv @@
// ---------------------------------------------------------------------------
// ffht_front
// Accepts request beats, decodes the action and range-checks the handle.
// ---------------------------------------------------------------------------
module ffht_front import ffht_pkg::*; #(
	parameter int TABLE_ENTRIES = 256
) (
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [7:0]  flow_proto,
	input  logic [31:0] local_address,
	input  logic [15:0] local_port,
	input  logic [31:0] remote_address,
	input  logic [15:0] remote_port,
	input  logic [15:0] owner_thread,
	input  logic [7:0]  slot_handle,
	input  logic        q_ready,
	input  logic        clear_done,
	output logic        push,
	output item_t       item
);

	// accept only once the store is cleared and the queue has room
	assign in_ready = q_ready & clear_done;
	assign push     = in_valid & in_ready;

	// classify the beat
	always_comb begin
		item.op        = op_t'(action);
		item.key.proto = flow_proto;
		item.key.laddr = local_address;
		item.key.lport = local_port;
		item.key.raddr = remote_address;
		item.key.rport = remote_port;
		item.thread    = owner_thread;
		item.handle    = slot_handle;
		item.handle_ok = (32'(slot_handle) < 32'(TABLE_ENTRIES));
	end

endmodule

@@ hdl/ffht_queue.sv @@
// ---------------------------------------------------------------------------
// ffht_queue
// Two-entry request queue between the front and the engine.
// ---------------------------------------------------------------------------
module ffht_queue import ffht_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  q_ready,
	input  logic  pop,
	output logic  q_valid,
	output item_t q_item
);

	item_t      slot_q [QDEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign q_ready = (count_q != 2'(QDEPTH));
	assign q_valid = (count_q != 2'd0);
	assign q_item  = slot_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_item;
	end

endmodule

@@ hdl/ffht_engine.sv @@
// ---------------------------------------------------------------------------
// ffht_engine
// Walks probe chains in the slot memories and produces one result per request.
// ---------------------------------------------------------------------------
`include "flow_filter_hash_table_core_defines.svh"

module ffht_engine import ffht_pkg::*; #(
	parameter int TABLE_ENTRIES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  item_t       q_item,
	output logic        pop,
	output logic        clear_done,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [7:0]  result_slot,
	output logic [15:0] found_thread,
	output logic [8:0]  occupied_count
);

	localparam int SW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(TABLE_ENTRIES + 1);

	eng_state_t state_q, state_d;

	// slot memories: kind and route count, key, thread
	logic [10:0]    meta_mem [TABLE_ENTRIES];
	key_t           key_mem  [TABLE_ENTRIES];
	logic [15:0]    thr_mem  [TABLE_ENTRIES];
	logic [10:0]    meta_rd_q;
	key_t           key_rd_q;
	logic [15:0]    thr_rd_q;

	// control registers
	logic [SW-1:0]  cur_q;
	logic [CW-1:0]  cnt_q;
	logic [CW-1:0]  occ_q;
	logic           wild_q;
	logic           out_valid_q;

	// payload registers
	item_t          item_q;
	logic [SW-1:0]  first_q, step_q, place_q;
	kind_t          place_kind_q;
	logic [8:0]     place_route_q;
	status_t        sts_q;
	logic [SW-1:0]  rslot_q;
	logic [15:0]    thr_q;
	status_t        out_sts_q;
	logic [SW-1:0]  out_slot_q;
	logic [15:0]    out_thr_q;
	logic [CW-1:0]  out_occ_q;

	// datapath helpers
	kind_t          kind_rd;
	logic [8:0]     route_rd, route_dn;
	logic [SW-1:0]  nxt_slot, ex_start, ex_step, wl_start, wl_step, rm_start, rm_step;
	logic [SW-1:0]  hslot;
	key_t           query;
	logic           hit, at_handle, rm_free, cnt_last, miss_end, out_free;
	logic           meta_we, ent_we, load_out;
	logic [10:0]    meta_wd;

	assign kind_rd   = kind_t'(meta_rd_q[10:9]);
	assign route_rd  = meta_rd_q[8:0];
	assign route_dn  = (route_rd != 9'd0) ? route_rd - 9'd1 : 9'd0;
	assign nxt_slot  = cur_q + step_q;
	assign ex_start  = SW'(fold_hash(q_item.key));
	assign ex_step   = SW'(step_hash(q_item.key));
	assign wl_start  = SW'(fold_hash(wild_key(item_q.key)));
	assign wl_step   = SW'(step_hash(wild_key(item_q.key)));
	assign rm_start  = SW'(fold_hash(key_rd_q));
	assign rm_step   = SW'(step_hash(key_rd_q));
	assign hslot     = SW'(q_item.handle);
	assign query     = wild_q ? wild_key(item_q.key) : item_q.key;
	assign hit       = (kind_rd == KIND_INUSE) && key_match(key_rd_q, query);
	assign at_handle = (cur_q == place_q);
	assign rm_free   = at_handle ? (route_dn == 9'd0)
	                             : (kind_rd == KIND_TOMB && route_dn == 9'd0);
	assign cnt_last  = (cnt_q == CW'(TABLE_ENTRIES - 1));
	assign miss_end  = (kind_rd == KIND_EMPTY) || cnt_last;
	assign out_free  = !out_valid_q || out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR:  if (&cur_q) state_d = S_IDLE;
			S_IDLE: begin
				if (q_valid) begin
					unique case (q_item.op)
						OP_ADD:    state_d = S_ADD_RD;
						OP_REMOVE: state_d = q_item.handle_ok ? S_RM_HRD : S_DONE;
						OP_LOOKUP: state_d = S_LK_RD;
						OP_NONE:   state_d = S_DONE;
						default:   state_d = S_DONE;
					endcase
				end
			end
			S_ADD_RD: state_d = S_ADD_EV;
			S_ADD_EV: begin
				priority if (kind_rd != KIND_INUSE)
					state_d = (cur_q == first_q) ? S_PLACE : S_INC_RD;
				else if (hit)
					state_d = S_DONE;
				else if (nxt_slot == first_q)
					state_d = S_DONE;
				else
					state_d = S_ADD_RD;
			end
			S_INC_RD: state_d = S_INC_EV;
			S_INC_EV: state_d = (nxt_slot == place_q) ? S_PLACE : S_INC_RD;
			S_PLACE:  state_d = S_DONE;
			S_RM_HRD: state_d = S_RM_HEV;
			S_RM_HEV: state_d = (kind_rd == KIND_INUSE) ? S_RM_RD : S_DONE;
			S_RM_RD:  state_d = S_RM_EV;
			S_RM_EV:  state_d = (at_handle || cnt_last) ? S_DONE : S_RM_RD;
			S_LK_RD:  state_d = S_LK_EV;
			S_LK_EV: begin
				priority if (hit)
					state_d = S_DONE;
				else if (miss_end)
					state_d = wild_q ? S_DONE : S_LK_RD;
				else
					state_d = S_LK_RD;
			end
			S_DONE:   if (out_free) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// memory writes and handshake outputs
	always_comb begin
		meta_we  = 1'b0;
		meta_wd  = 11'd0;
		ent_we   = 1'b0;
		pop      = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				meta_we = 1'b1;
				meta_wd = {KIND_EMPTY, 9'd0};
			end
			S_IDLE:   pop = q_valid;
			S_INC_EV: begin
				meta_we = 1'b1;
				meta_wd = {kind_rd, route_inc(route_rd)};
			end
			S_PLACE: begin
				meta_we = 1'b1;
				meta_wd = {KIND_INUSE, route_inc(place_route_q)};
				ent_we  = 1'b1;
			end
			S_RM_EV: begin
				meta_we = 1'b1;
				if (at_handle)
					meta_wd = {(route_dn != 9'd0) ? KIND_TOMB : KIND_EMPTY, route_dn};
				else
					meta_wd = {rm_free ? KIND_EMPTY : kind_rd, route_dn};
			end
			S_DONE:   load_out = out_free;
			default: ;
		endcase
	end

	// slot memories, read every cycle at the current slot
	always_ff @(posedge clk) begin
		if (meta_we)
			meta_mem[cur_q] <= meta_wd;
		meta_rd_q <= meta_mem[cur_q];
	end

	always_ff @(posedge clk) begin
		if (ent_we) begin
			key_mem[cur_q] <= item_q.key;
			thr_mem[cur_q] <= item_q.thread;
		end
		key_rd_q <= key_mem[cur_q];
		thr_rd_q <= thr_mem[cur_q];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			cur_q       <= '0;
			cnt_q       <= '0;
			occ_q       <= '0;
			wild_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= load_out | (out_valid_q & ~out_ready);
			unique case (state_q)
				S_CLEAR: cur_q <= cur_q + SW'(1);
				S_IDLE: begin
					if (q_valid) begin
						cur_q  <= (q_item.op == OP_REMOVE) ? hslot : ex_start;
						cnt_q  <= '0;
						wild_q <= 1'b0;
					end
				end
				S_ADD_EV: begin
					if (kind_rd != KIND_INUSE)
						cur_q <= first_q;
					else if (!hit)
						cur_q <= nxt_slot;
				end
				S_INC_EV: cur_q <= nxt_slot;
				S_PLACE: begin
					if (place_kind_q == KIND_EMPTY)
						occ_q <= occ_q + CW'(1);
				end
				S_RM_HEV: begin
					cur_q <= rm_start;
					cnt_q <= '0;
				end
				S_RM_EV: begin
					if (rm_free && occ_q != '0)
						occ_q <= occ_q - CW'(1);
					cur_q <= nxt_slot;
					cnt_q <= cnt_q + CW'(1);
				end
				S_LK_EV: begin
					if (!hit) begin
						if (miss_end && !wild_q) begin
							wild_q <= 1'b1;
							cur_q  <= wl_start;
							cnt_q  <= '0;
						end else begin
							cur_q <= nxt_slot;
							cnt_q <= cnt_q + CW'(1);
						end
					end
				end
				default: ;
			endcase
		end
	end

	// request payload and result fields
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					item_q  <= q_item;
					first_q <= ex_start;
					step_q  <= ex_step;
					place_q <= hslot;
					sts_q   <= (q_item.op == OP_REMOVE) ? STS_BADHDL : STS_NOTFOUND;
					rslot_q <= '0;
					thr_q   <= 16'd0;
				end
			end
			S_ADD_EV: begin
				priority if (kind_rd != KIND_INUSE) begin
					place_q       <= cur_q;
					place_kind_q  <= kind_rd;
					place_route_q <= route_rd;
				end else if (hit) begin
					sts_q   <= STS_DUP;
					rslot_q <= cur_q;
				end else if (nxt_slot == first_q) begin
					sts_q <= STS_FULL;
				end
			end
			S_PLACE: begin
				sts_q   <= STS_OK;
				rslot_q <= place_q;
			end
			S_RM_HEV: step_q <= rm_step;
			S_RM_EV: begin
				priority if (at_handle) begin
					sts_q   <= STS_OK;
					rslot_q <= place_q;
				end else if (cnt_last) begin
					sts_q <= STS_NOTFOUND;
				end
			end
			S_LK_EV: begin
				priority if (hit) begin
					sts_q   <= STS_OK;
					rslot_q <= cur_q;
					thr_q   <= thr_rd_q;
				end else if (miss_end && !wild_q) begin
					step_q <= wl_step;
				end
			end
			S_DONE: begin
				if (load_out) begin
					out_sts_q  <= sts_q;
					out_slot_q <= rslot_q;
					out_thr_q  <= thr_q;
					out_occ_q  <= occ_q;
				end
			end
			default: ;
		endcase
	end

	assign clear_done     = (state_q != S_CLEAR);
	assign out_valid      = out_valid_q;
	assign status         = out_sts_q;
	assign result_slot    = 8'(out_slot_q);
	assign found_thread   = out_thr_q;
	assign occupied_count = 9'(out_occ_q);

	// checks
	`FFHT_CHECK(a_occ_bound, occ_q <= CW'(TABLE_ENTRIES), "occupancy above table size")
	`FFHT_CHECK(a_pop_idle, !pop || (state_q == S_IDLE && clear_done), "pop outside idle")
	`FFHT_CHECK_NEXT(a_done_hold, state_q == S_DONE && !out_free, state_q == S_DONE,
		"result dropped while output busy")

endmodule

@@ hdl/flow_filter_hash_table_core.sv @@
// ---------------------------------------------------------------------------
// flow_filter_hash_table_core
// Flow filter table with double hashing, tombstones and route counts.
// ---------------------------------------------------------------------------
// After reset the block sweeps the slot state memory once before in_ready
// rises. Requests then pass through a two-entry queue to the engine, which
// visits each probed slot with a memory read, then a compare and update.
// A lookup probes the chain of the exact key and, on a miss, runs a wildcard
// retry; an add probes slots, then raises the route count of each chain slot
// up to the placed one; a remove walks the chain up to the handle.
// One result beat comes out per request, held in an output register so the
// engine can go on meanwhile.
module flow_filter_hash_table_core import ffht_pkg::*; #(
	parameter int TABLE_ENTRIES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [7:0]  flow_proto,
	input  logic [31:0] local_address,
	input  logic [15:0] local_port,
	input  logic [31:0] remote_address,
	input  logic [15:0] remote_port,
	input  logic [15:0] owner_thread,
	input  logic [7:0]  slot_handle,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [7:0]  result_slot,
	output logic [15:0] found_thread,
	output logic [8:0]  occupied_count
);

	logic  push, q_ready, q_valid, pop, clear_done;
	item_t push_item, q_item;

	// request decode
	ffht_front #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_front (
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.action         (action),
		.flow_proto     (flow_proto),
		.local_address  (local_address),
		.local_port     (local_port),
		.remote_address (remote_address),
		.remote_port    (remote_port),
		.owner_thread   (owner_thread),
		.slot_handle    (slot_handle),
		.q_ready        (q_ready),
		.clear_done     (clear_done),
		.push           (push),
		.item           (push_item)
	);

	// request queue
	ffht_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.q_ready   (q_ready),
		.pop       (pop),
		.q_valid   (q_valid),
		.q_item    (q_item)
	);

	// table engine
	ffht_engine #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_engine (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_item         (q_item),
		.pop            (pop),
		.clear_done     (clear_done),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.result_slot    (result_slot),
		.found_thread   (found_thread),
		.occupied_count (occupied_count)
	);

endmodule

@@ tb/sv/flow_filter_hash_table_core_checker.sv @@
// ---------------------------------------------------------------------------
// flow_filter_hash_table_core_checker
// Watches the request and result channels of the flow filter table, keeps
// its own copy of the table to predict each result beat, and counts
// mismatches against the oldest pending prediction.
// ---------------------------------------------------------------------------
module flow_filter_hash_table_core_checker import ffht_pkg::*; #(
	parameter int TABLE_ENTRIES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  action,
	input  logic [7:0]  flow_proto,
	input  logic [31:0] local_address,
	input  logic [15:0] local_port,
	input  logic [31:0] remote_address,
	input  logic [15:0] remote_port,
	input  logic [15:0] owner_thread,
	input  logic [7:0]  slot_handle,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [2:0]  status,
	input  logic [7:0]  result_slot,
	input  logic [15:0] found_thread,
	input  logic [8:0]  occupied_count,
	output int          fail_count,
	output int          pending_count
);

	localparam int MASK = TABLE_ENTRIES - 1;

	typedef struct packed {
		logic [2:0]  sts;
		logic [7:0]  slot;
		logic [15:0] thr;
		logic [8:0]  occ;
	} answer_t;

	kind_t       tbl_kind[TABLE_ENTRIES];
	logic [8:0]  tbl_route[TABLE_ENTRIES];
	key_t        tbl_key[TABLE_ENTRIES];
	logic [15:0] tbl_thread[TABLE_ENTRIES];
	int          tbl_occupied;
	answer_t     answers_due[$];

	function automatic logic [31:0] mix(key_t k);
		return k.laddr ^ {16'h0, k.lport} ^ k.raddr ^ {16'h0, k.rport} ^ {24'h0, k.proto};
	endfunction

	function automatic int home_slot(key_t k);
		logic [31:0] h;
		h = mix(k);
		h = h ^ (h >> 16);
		h = h ^ (h >> 8);
		return int'(h) & MASK;
	endfunction

	function automatic int stride(key_t k);
		return int'(mix(k) | 32'd1) & MASK;
	endfunction

	function automatic bit slot_hit(int s, key_t q);
		key_t e;
		e = tbl_key[s];
		if (tbl_kind[s] != KIND_INUSE)
			return 0;
		if (e.proto != q.proto || e.laddr != q.laddr || e.lport != q.lport)
			return 0;
		if (q.raddr != 0 || q.rport != 0)
			return e.raddr == q.raddr && e.rport == q.rport;
		return 1;
	endfunction

	function automatic int search(key_t q);
		int s;
		int st;
		s = home_slot(q);
		st = stride(q);
		for (int n = 0; n < TABLE_ENTRIES; n++) begin
			if (slot_hit(s, q))
				return s;
			if (tbl_kind[s] == KIND_EMPTY)
				return -1;
			s = (s + st) & MASK;
		end
		return -1;
	endfunction

	// apply one request to the table copy and return its result
	function automatic answer_t table_update(op_t op, key_t q, logic [15:0] thr,
			logic [7:0] hdl);
		answer_t a;
		int first;
		int st;
		int s;
		int t;
		int r;
		bit placed;
		key_t k;
		a = '0;
		a.sts = STS_NOTFOUND;
		case (op)
			OP_ADD: begin
				first = home_slot(q);
				st = stride(q);
				s = first;
				placed = 0;
				a.sts = STS_FULL;
				do begin
					if (tbl_kind[s] != KIND_INUSE) begin
						placed = 1;
						break;
					end
					if (slot_hit(s, q)) begin
						a.sts = STS_DUP;
						a.slot = 8'(s);
						break;
					end
					s = (s + st) & MASK;
				end while (s != first);
				if (placed) begin
					t = first;
					while (t != s) begin
						if (tbl_route[t] != ROUTE_MAX)
							tbl_route[t]++;
						t = (t + st) & MASK;
					end
					if (tbl_kind[s] == KIND_EMPTY)
						tbl_occupied++;
					tbl_kind[s] = KIND_INUSE;
					if (tbl_route[s] != ROUTE_MAX)
						tbl_route[s]++;
					tbl_key[s] = q;
					tbl_thread[s] = thr;
					a.sts = STS_OK;
					a.slot = 8'(s);
				end
			end
			OP_REMOVE: begin
				if (int'(hdl) >= TABLE_ENTRIES || tbl_kind[hdl] != KIND_INUSE) begin
					a.sts = STS_BADHDL;
				end else begin
					k = tbl_key[hdl];
					s = home_slot(k);
					st = stride(k);
					for (int n = 0; n < TABLE_ENTRIES; n++) begin
						if (tbl_route[s] != 0)
							tbl_route[s]--;
						if (s == int'(hdl)) begin
							if (tbl_route[s] != 0) begin
								tbl_kind[s] = KIND_TOMB;
							end else begin
								tbl_kind[s] = KIND_EMPTY;
								if (tbl_occupied > 0)
									tbl_occupied--;
							end
							a.sts = STS_OK;
							a.slot = hdl;
							break;
						end
						if (tbl_kind[s] == KIND_TOMB && tbl_route[s] == 0) begin
							tbl_kind[s] = KIND_EMPTY;
							if (tbl_occupied > 0)
								tbl_occupied--;
						end
						s = (s + st) & MASK;
					end
				end
			end
			OP_LOOKUP: begin
				r = search(q);
				if (r < 0) begin
					k = q;
					k.raddr = '0;
					k.rport = '0;
					r = search(k);
				end
				if (r >= 0) begin
					a.sts = STS_OK;
					a.slot = 8'(r);
					a.thr = tbl_thread[r];
				end
			end
			default: ;
		endcase
		a.occ = 9'(tbl_occupied);
		return a;
	endfunction

	// predict on request beats, compare on result beats
	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		key_t q;
		if (!arst_n) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				tbl_kind[i] = KIND_EMPTY;
				tbl_route[i] = '0;
				tbl_key[i] = '0;
				tbl_thread[i] = '0;
			end
			tbl_occupied = 0;
			answers_due.delete();
			fail_count <= 0;
			pending_count <= 0;
		end else begin
			if (in_valid && in_ready) begin
				q = '{flow_proto, local_address, local_port, remote_address, remote_port};
				answers_due.push_back(table_update(op_t'(action), q, owner_thread,
					slot_handle));
			end
			if (out_valid && out_ready) begin
				if (answers_due.size() == 0) begin
					$display("%0t: unexpected result beat status %0d slot %0d", $time,
						status, result_slot);
					fail_count <= fail_count + 1;
				end else begin
					want = answers_due.pop_front();
					if (want != {status, result_slot, found_thread, occupied_count}) begin
						$display("%0t: expected sts %0d slot %0d thr %h occ %0d, got sts %0d slot %0d thr %h occ %0d",
							$time, want.sts, want.slot, want.thr, want.occ,
							status, result_slot, found_thread, occupied_count);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending_count <= answers_due.size();
		end
	end

endmodule

@@ tb/sv/flow_filter_hash_table_core_tb.sv @@
// ---------------------------------------------------------------------------
// flow_filter_hash_table_core_tb
// Drives add, remove, lookup and no-op requests into the flow filter table with
// random idling on both channels; the checker predicts and compares.
// ---------------------------------------------------------------------------
module flow_filter_hash_table_core_tb import ffht_pkg::*;;

	localparam int WATCHDOG_LIMIT = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  action = OP_LOOKUP;
	logic [7:0]  flow_proto = '0;
	logic [31:0] local_address = '0;
	logic [15:0] local_port = '0;
	logic [31:0] remote_address = '0;
	logic [15:0] remote_port = '0;
	logic [15:0] owner_thread = '0;
	logic [7:0]  slot_handle = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  status;
	logic [7:0]  result_slot;
	logic [15:0] found_thread;
	logic [8:0]  occupied_count;
	int          fail_count;
	int          pending_count;
	int          send_idle_pct = 22;
	int          recv_idle_pct = 46;
	int          quiet_cycles = 0;
	key_t        known_keys[$];
	logic [7:0]  known_slots[$];

	always #4 clk = ~clk;

	flow_filter_hash_table_core DUT (.*);

	flow_filter_hash_table_core_checker checker_inst (.*);

	// receiver stalls
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_idle_pct);

	// slots reported by ok result beats, kept for later removes
	always @(posedge clk) begin
		if (out_valid && out_ready && status == STS_OK) begin
			if (known_slots.size() >= 64)
				void'(known_slots.pop_front());
			known_slots.push_back(result_slot);
		end
	end

	// watchdog on accepted beats
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL flow_filter_hash_table_core");
			$finish;
		end
	end

	// one request beat, held until accepted
	task automatic send_request(op_t op, key_t k, logic [15:0] thr, logic [7:0] hdl);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= op;
		{flow_proto, local_address, local_port, remote_address, remote_port} <= k;
		owner_thread <= thr;
		slot_handle <= hdl;
		do
			@(posedge clk);
		while (!in_ready);
		if (op == OP_ADD)
			known_keys.push_back(k);
	endtask

	function automatic key_t rand_key(bit narrow);
		key_t k;
		k.proto = 8'($urandom);
		k.laddr = $urandom;
		k.lport = 16'($urandom);
		k.raddr = $urandom;
		k.rport = 16'($urandom);
		if (narrow) begin
			k.proto = $urandom_range(1) ? 8'd6 : 8'd17;
			k.laddr = 32'h0a000000 | $urandom_range(7);
			k.lport = 16'($urandom_range(3));
			k.raddr = $urandom_range(3) == 0 ? 32'd0 : 32'hc0a80000 | $urandom_range(3);
			k.rport = k.raddr == 0 ? 16'd0 : 16'($urandom_range(3));
		end
		return k;
	endfunction

	task automatic random_phase(int count);
		key_t k;
		int pick;
		logic [7:0] hdl;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (pick < 40) begin
				send_request(OP_ADD, rand_key($urandom_range(3) != 0), 16'($urandom), 8'd0);
			end else if (pick < 65) begin
				// remove by handle, mostly a slot seen in a result
				if (known_slots.size() > 0 && $urandom_range(3) != 0)
					hdl = known_slots[$urandom_range(known_slots.size() - 1)];
				else
					hdl = 8'($urandom);
				send_request(OP_REMOVE, rand_key(0), 16'($urandom), hdl);
			end else if (pick < 97) begin
				if (known_keys.size() > 0 && $urandom_range(1)) begin
					k = known_keys[$urandom_range(known_keys.size() - 1)];
					if ($urandom_range(3) == 0)
						k.rport = 16'($urandom);
				end else begin
					k = rand_key(1'($urandom_range(1)));
				end
				send_request(OP_LOOKUP, k, 16'($urandom), 8'($urandom));
			end else begin
				send_request(OP_NONE, rand_key(0), 16'($urandom), 8'($urandom));
			end
		end
	endtask

	initial begin
		key_t k;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		// directed: extremes, each action, wildcard, duplicate, bad handle
		send_request(OP_LOOKUP, '0, 16'h0, 8'h0);
		send_request(OP_ADD, '0, 16'hffff, 8'h0);
		send_request(OP_ADD, '0, 16'h1234, 8'h0);
		send_request(OP_ADD, '1, 16'h0, 8'hff);
		send_request(OP_LOOKUP, '1, 16'h0, 8'h0);
		k = '{8'd6, 32'h0a000001, 16'd80, 32'd0, 16'd0};
		send_request(OP_ADD, k, 16'h00aa, 8'h0);
		k.raddr = 32'hc0a80001;
		k.rport = 16'd5000;
		send_request(OP_LOOKUP, k, 16'h0, 8'h0);
		send_request(OP_ADD, k, 16'h00bb, 8'h0);
		send_request(OP_ADD, k, 16'h00cc, 8'h0);
		send_request(OP_LOOKUP, k, 16'h0, 8'h0);
		k.raddr = 32'd0;
		k.rport = 16'd0;
		send_request(OP_ADD, k, 16'h00dd, 8'h0);
		send_request(OP_REMOVE, '0, 16'h0, 8'hff);
		send_request(OP_REMOVE, '0, 16'h0, 8'h00);
		send_request(OP_REMOVE, '0, 16'h0, 8'h00);
		send_request(OP_LOOKUP, '0, 16'h0, 8'h0);
		send_request(OP_NONE, '1, 16'hffff, 8'hff);
		// colliding keys on one chain, then remove the head to make a tombstone
		for (int i = 0; i < 4; i++)
			send_request(OP_ADD, '{8'd17, 32'h00000101 * i, 16'd0, 32'd0, 16'd0},
				16'(i), 8'h0);
		send_request(OP_REMOVE, '0, 16'h0, 8'h11);
		send_request(OP_ADD, '{8'd17, 32'h00000404, 16'd0, 32'd0, 16'd0}, 16'h7, 8'h0);
		random_phase(150);
		send_idle_pct = 46;
		recv_idle_pct = 22;
		random_phase(150);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(150);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (600) @(posedge clk);
		if (fail_count == 0 && pending_count == 0)
			$display("PASS flow_filter_hash_table_core");
		else
			$display("FAIL flow_filter_hash_table_core");
		$finish;
	end

endmodule
